// ===== rtl/core/wsd_pkg.sv =====
// Shared types and constants of the WAV stream to DAC decoder.
`timescale 1ns / 1ps
`default_nettype none
package wsd_pkg;

  // Input item: restart flag and one stream byte
  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_t;

  // Result item
  typedef struct packed {
    logic        sample_valid;
    logic [11:0] sample;
    logic [2:0]  phase;
    logic        file_done;
    logic [31:0] sample_rate;
  } out_t;

  // Classified item from the parser to the sample stage
  typedef struct packed {
    logic            sample_valid;
    logic            is8;
    logic            stereo;
    logic [3:0][7:0] frame;
    logic [2:0]      phase;
    logic            file_done;
    logic [31:0]     sample_rate;
  } job_t;

  // Operation codes of the input item
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Reported phase codes
  localparam logic [2:0] PHASE_RIFF = 3'd0;
  localparam logic [2:0] PHASE_CHDR = 3'd1;
  localparam logic [2:0] PHASE_BODY = 3'd2;
  localparam logic [2:0] PHASE_PLAY = 3'd3;
  localparam logic [2:0] PHASE_BAD  = 3'd4;

  // Tags, little-endian byte order
  localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
  localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
  localparam logic [31:0] ID_FMT   = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA  = 32'h6174_6164;

  // Format constants
  localparam logic [15:0] FMT_PCM    = 16'd1;
  localparam logic [15:0] BITS_8     = 16'd8;
  localparam logic [15:0] BITS_16    = 16'd16;
  localparam logic [15:0] CH_MONO    = 16'd1;
  localparam logic [15:0] CH_STEREO  = 16'd2;
  localparam logic [15:0] ALIGN_MAX  = 16'd4;
  localparam int unsigned FMT_BYTES  = 16;

  // Volume register
  localparam int unsigned VOL_W     = 5;
  localparam logic [4:0]  VOL_RESET = 5'd1;
  localparam logic [4:0]  VOL_LIMIT = 5'd16;

  // Sample arithmetic
  localparam logic [11:0] DAC_MAX = 12'hFFF;

endpackage
`default_nettype wire

// ===== rtl/core/wsd_fifo.sv =====
// Small first-in first-out queue of fixed-width entries.
`timescale 1ns / 1ps
`default_nettype none
module wsd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PtrLast = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CntFull = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wsd_front.sv =====
// Front end: parses the RIFF/WAVE byte stream and collects PCM frames.
`timescale 1ns / 1ps
`default_nettype none
module wsd_front #(
  parameter int unsigned MAX_CHUNK = 18
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire wsd_pkg::in_t in_i,
  output wsd_pkg::job_t     job_o
);

  localparam int unsigned IW = $clog2(MAX_CHUNK + 1);
  localparam logic [31:0]   MaxLen   = 32'(MAX_CHUNK);
  localparam logic [IW-1:0] IdxTag1  = IW'(4);
  localparam logic [IW-1:0] IdxSize  = IW'(8);
  localparam logic [IW-1:0] IdxLast  = IW'(11);
  localparam logic [IW-1:0] IdxFmt   = IW'(wsd_pkg::FMT_BYTES);
  localparam logic [IW-1:0] IdxMax   = IW'(MAX_CHUNK);

  typedef enum logic [4:0] {
    PH_RIFF = 5'b00001,
    PH_CHDR = 5'b00010,
    PH_BODY = 5'b00100,
    PH_PLAY = 5'b01000,
    PH_BAD  = 5'b10000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [31:0]     pos_q, pos_d;
  logic [31:0]     riff_q, riff_d;
  logic            match_q, match_d;
  logic [31:0]     id_q, id_d;
  logic [31:0]     len_q, len_d;
  logic [7:0]      fmt_q [wsd_pkg::FMT_BYTES];
  logic [7:0]      fmt_d [wsd_pkg::FMT_BYTES];
  logic [3:0][7:0] frame_q, frame_d;
  logic [2:0]      fcnt_q, fcnt_d;

  logic [7:0]      b;
  logic [15:0]     fmt_tag, fmt_ch, fmt_ba, fmt_bits;
  logic            fmt_ok;
  logic [2:0]      hb;
  logic [IW:0]     idx_inc;
  logic [3:0][7:0] fill;
  logic [2:0]      fcnt_n;
  logic            restart;
  logic            frame_done;
  logic            done;
  logic [2:0]      phase_code;

  assign b        = in_i.data_byte;
  assign fmt_tag  = {fmt_q[1], fmt_q[0]};
  assign fmt_ch   = {fmt_q[3], fmt_q[2]};
  assign fmt_ba   = {fmt_q[13], fmt_q[12]};
  assign fmt_bits = {fmt_q[15], fmt_q[14]};
  assign hb       = idx_q[2:0];
  assign idx_inc  = {1'b0, idx_q} + {{IW{1'b0}}, 1'b1};
  assign fcnt_n   = fcnt_q + 3'd1;

  // Check the stored format at the data chunk header
  assign fmt_ok = (fmt_tag == wsd_pkg::FMT_PCM) &&
                  ((fmt_ch == wsd_pkg::CH_MONO) || (fmt_ch == wsd_pkg::CH_STEREO)) &&
                  (fmt_ba != '0) && (fmt_ba <= wsd_pkg::ALIGN_MAX) &&
                  ((fmt_bits == wsd_pkg::BITS_8) || (fmt_bits == wsd_pkg::BITS_16));

  // Next parser state for one byte
  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    riff_d     = riff_q;
    match_d    = match_q;
    id_d       = id_q;
    len_d      = len_q;
    fmt_d      = fmt_q;
    frame_d    = frame_q;
    fcnt_d     = fcnt_q;
    fill       = frame_q;
    restart    = 1'b0;
    frame_done = 1'b0;
    done       = 1'b0;
    if (in_i.op == wsd_pkg::OP_RESTART) begin
      restart = 1'b1;
    end else begin
      unique case (phase_q)
        PH_RIFF: begin
          if (idx_q < IdxTag1) begin
            match_d = match_q && (b == wsd_pkg::RIFF_TAG[{idx_q[1:0], 3'b000} +: 8]);
          end else if (idx_q < IdxSize) begin
            riff_d[{idx_q[1:0], 3'b000} +: 8] = b;
          end else begin
            match_d = match_q && (b == wsd_pkg::WAVE_TAG[{idx_q[1:0], 3'b000} +: 8]);
          end
          if (idx_q == IdxLast) begin
            idx_d = '0;
            if (match_d) begin
              phase_d = PH_CHDR;
              pos_d   = 32'd4;
            end else begin
              phase_d = PH_BAD;
            end
          end else begin
            idx_d = idx_inc[IW-1:0];
          end
        end
        PH_CHDR: begin
          pos_d = pos_q + 32'd1;
          if (hb == 3'd0) begin
            id_d  = '0;
            len_d = '0;
          end
          if (!hb[2]) begin
            id_d[{hb[1:0], 3'b000} +: 8] = b;
          end else begin
            len_d[{hb[1:0], 3'b000} +: 8] = b;
          end
          if (hb == 3'd7) begin
            idx_d = '0;
            if (id_d == wsd_pkg::ID_DATA) begin
              if (fmt_ok) begin
                phase_d = PH_PLAY;
                fcnt_d  = '0;
                frame_d = '0;
              end else begin
                phase_d = PH_BAD;
              end
            end else if (len_d > MaxLen) begin
              phase_d = PH_BAD;
            end else if (len_d != '0) begin
              phase_d = PH_BODY;
            end
          end else begin
            idx_d = idx_inc[IW-1:0];
          end
        end
        PH_BODY: begin
          pos_d = pos_q + 32'd1;
          // Keep only the first 16 bytes of the fmt chunk
          if ((id_q == wsd_pkg::ID_FMT) && (idx_q < IdxFmt) && (idx_q < IdxMax)) begin
            fmt_d[idx_q[3:0]] = b;
          end
          if (idx_inc >= {1'b0, len_q[IW-1:0]}) begin
            phase_d = PH_CHDR;
            idx_d   = '0;
          end else begin
            idx_d = idx_inc[IW-1:0];
          end
        end
        PH_PLAY: begin
          pos_d = pos_q + 32'd1;
          fill[fcnt_q[1:0]] = b;
          if ({13'd0, fcnt_n} >= fmt_ba) begin
            frame_done = 1'b1;
            fcnt_d     = '0;
            frame_d    = '0;
            if (pos_d >= riff_q) begin
              done    = 1'b1;
              restart = 1'b1;
            end
          end else begin
            fcnt_d  = fcnt_n;
            frame_d = fill;
          end
        end
        PH_BAD: begin
          // Drop bytes until a restart
        end
        default: begin
          phase_d = PH_BAD;
        end
      endcase
    end
    // Return to the header phase, clear only the format tag of the store
    if (restart) begin
      phase_d  = PH_RIFF;
      idx_d    = '0;
      pos_d    = '0;
      riff_d   = '0;
      match_d  = 1'b1;
      id_d     = '0;
      len_d    = '0;
      fmt_d[0] = '0;
      fmt_d[1] = '0;
      frame_d  = '0;
      fcnt_d   = '0;
    end
  end

  // Encode the reported phase
  always_comb begin
    unique case (phase_d)
      PH_RIFF: phase_code = wsd_pkg::PHASE_RIFF;
      PH_CHDR: phase_code = wsd_pkg::PHASE_CHDR;
      PH_BODY: phase_code = wsd_pkg::PHASE_BODY;
      PH_PLAY: phase_code = wsd_pkg::PHASE_PLAY;
      default: phase_code = wsd_pkg::PHASE_BAD;
    endcase
  end

  // Build the item for the sample stage
  always_comb begin
    job_o.sample_valid = frame_done;
    job_o.is8          = (fmt_bits == wsd_pkg::BITS_8);
    job_o.stereo       = (fmt_ch == wsd_pkg::CH_STEREO);
    job_o.frame        = fill;
    job_o.phase        = phase_code;
    job_o.file_done    = done;
    job_o.sample_rate  = {fmt_d[7], fmt_d[6], fmt_d[5], fmt_d[4]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      idx_q   <= '0;
      pos_q   <= '0;
      riff_q  <= '0;
      match_q <= 1'b1;
      id_q    <= '0;
      len_q   <= '0;
      fmt_q   <= '{default: '0};
      frame_q <= '0;
      fcnt_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      riff_q  <= riff_d;
      match_q <= match_d;
      id_q    <= id_d;
      len_q   <= len_d;
      fmt_q   <= fmt_d;
      frame_q <= frame_d;
      fcnt_q  <= fcnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wsd_back.sv =====
// Back end: turns a collected frame into a 12-bit DAC value with volume.
`timescale 1ns / 1ps
`default_nettype none
module wsd_back #(
  parameter int unsigned VOLUME_SHIFT = 4
) (
  input  wire wsd_pkg::job_t job_i,
  input  wire logic [4:0]  volume_i,
  output wsd_pkg::out_t    res_o
);

  logic [11:0] v0, v1;
  logic [12:0] mix_sum;
  logic [11:0] mix;
  logic [16:0] prod;
  logic [16:0] scaled;
  logic [11:0] level;

  // Unsigned 12-bit value per channel: shift 8-bit, bias 16-bit
  always_comb begin
    if (job_i.is8) begin
      v0 = {job_i.frame[0], 4'b0000};
      v1 = {job_i.frame[1], 4'b0000};
    end else begin
      v0 = {~job_i.frame[1][7], job_i.frame[1][6:0], job_i.frame[0][7:4]};
      v1 = {~job_i.frame[3][7], job_i.frame[3][6:0], job_i.frame[2][7:4]};
    end
  end

  // Average stereo, scale by volume, saturate
  assign mix_sum = {1'b0, v0} + {1'b0, v1};
  assign mix     = job_i.stereo ? mix_sum[12:1] : v0;
  assign prod    = {5'd0, mix} * {12'd0, volume_i};
  assign scaled  = prod >> VOLUME_SHIFT;
  assign level   = (scaled > {5'd0, wsd_pkg::DAC_MAX}) ? wsd_pkg::DAC_MAX : scaled[11:0];

  always_comb begin
    res_o.sample_valid = job_i.sample_valid;
    res_o.sample       = job_i.sample_valid ? level : '0;
    res_o.phase        = job_i.phase;
    res_o.file_done    = job_i.file_done;
    res_o.sample_rate  = job_i.sample_rate;
  end

endmodule
`default_nettype wire

// ===== rtl/core/wav_stream_to_dac_decoder.sv =====
// Top level of the WAV stream to DAC decoder.
//
//  channel   direction  handshake                 payload
//  input     in         push / full               in_data_i  (op, data_byte)
//  result    out        empty / pop               out_data_o (sample_valid .. sample_rate)
//  config    in         cfg_valid_i / cfg_ready_o cfg_volume_i (volume)
//
// One byte is taken per cycle while full is low; the parser updates its state in the accepting cycle.
// A result is first registered in the parser-to-sample queue; the combinational sample stage
// then writes it into the result queue when that queue has room, from where it is popped.
// Each queue holds two items, so either side may stall without a bubble.
// Reset is asynchronous and active low; it clears the parser and queues and sets the volume to 1.
`timescale 1ns / 1ps
`default_nettype none
module wav_stream_to_dac_decoder #(
  parameter int unsigned MAX_CHUNK    = 18,
  parameter int unsigned VOLUME_SHIFT = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire wsd_pkg::in_t in_data_i,
  input  wire logic         pop,
  output logic              empty,
  output wsd_pkg::out_t     out_data_o,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [4:0]   cfg_volume_i
);

  localparam int unsigned JobW = $bits(wsd_pkg::job_t);
  localparam int unsigned ResW = $bits(wsd_pkg::out_t);

  logic                accept;
  wsd_pkg::job_t       job_in, job_out;
  logic [JobW-1:0]     job_rdata;
  logic                mid_full, mid_empty, mid_pop;
  wsd_pkg::out_t       res;
  logic [ResW-1:0]     res_rdata;
  logic                out_full;
  logic [4:0]          volume_q, volume_d;

  assign accept      = push && !full;
  assign full        = mid_full;
  assign cfg_ready_o = 1'b1;

  // Clamp volume writes
  assign volume_d = (cfg_volume_i > wsd_pkg::VOL_LIMIT) ? wsd_pkg::VOL_LIMIT : cfg_volume_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= wsd_pkg::VOL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      volume_q <= volume_d;
    end
  end

  wsd_front #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .job_o    (job_in)
  );

  wsd_fifo #(
    .WIDTH (JobW),
    .DEPTH (2)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (job_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (job_rdata),
    .empty_o (mid_empty)
  );

  // Move one item to the result queue when it has room
  assign mid_pop = !mid_empty && !out_full;
  assign job_out = wsd_pkg::job_t'(job_rdata);

  wsd_back #(
    .VOLUME_SHIFT (VOLUME_SHIFT)
  ) u_back (
    .job_i    (job_out),
    .volume_i (volume_q),
    .res_o    (res)
  );

  wsd_fifo #(
    .WIDTH (ResW),
    .DEPTH (2)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_pop),
    .wdata_i (res),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign out_data_o = wsd_pkg::out_t'(res_rdata);

  // A transfer in leaves the middle queue holding at least one item
  a_mid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !mid_empty)
    else $error("middle queue empty after input transfer");

  // The sample stage never moves an item into a full result queue
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !out_full)
    else $error("item moved into full result queue");

  // Volume stays within its clamp after a write
  a_vol_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> (volume_q <= wsd_pkg::VOL_LIMIT))
    else $error("volume above limit");

endmodule
`default_nettype wire
